@@ design/fpq8_pkg.sv @@
`default_nettype none
package fpq8_pkg;

    localparam int FRAC_BITS = 8;
    // Width of the scaled dividend |a| << FRAC_BITS, and so of the quotient.
    localparam int NUM_W = 32 + FRAC_BITS;

    localparam logic [3:0] OP_ADD        = 4'd0;
    localparam logic [3:0] OP_SUB        = 4'd1;
    localparam logic [3:0] OP_MUL        = 4'd2;
    localparam logic [3:0] OP_DIV        = 4'd3;
    localparam logic [3:0] OP_CMP        = 4'd4;
    localparam logic [3:0] OP_MIN        = 4'd5;
    localparam logic [3:0] OP_MAX        = 4'd6;
    localparam logic [3:0] OP_INC        = 4'd7;
    localparam logic [3:0] OP_DEC        = 4'd8;
    localparam logic [3:0] OP_INT_TO_FIX = 4'd9;
    localparam logic [3:0] OP_FIX_TO_INT = 4'd10;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic        [3:0]  opcode;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result;
        logic               less;
        logic               equal;
        logic               greater;
        logic               range_error;
        logic               divide_by_zero;
    } t_out_item;

    typedef enum logic [2:0] {
        K_SIMPLE = 3'b001,
        K_MUL    = 3'b010,
        K_DIV    = 3'b100
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        neg;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        t_out_item   out;
    } t_work;

    // Applies a sign to a magnitude, saturating to 32 bits; bit 32 flags saturation.
    function automatic logic [32:0] signed_sat(input logic neg, input logic [63:0] mag);
        logic [32:0] r;
        if (!neg) begin
            if (mag > {32'd0, SAT_MAX}) begin
                r = {1'b1, SAT_MAX};
            end else begin
                r = {1'b0, mag[31:0]};
            end
        end else begin
            if (mag > {32'd0, SAT_MIN}) begin
                r = {1'b1, SAT_MIN};
            end else begin
                r = {1'b0, 32'd0 - mag[31:0]};
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ design/fixed_point_q8_alu.sv @@
// Operands and results are Q24.8; a beat moves from the front queue through the back stages to the output register.
// Throughput: one beat per cycle, sustained while results are popped as they appear.
// The divide pipeline, one quotient bit per stage over NUM_W stages, sets the latency.
// Reset (synchronous, active low) empties the input queue and clears every valid bit.
`default_nettype none
module fixed_point_q8_alu (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    input  wire fpq8_pkg::t_in_item i_item,
    output logic                    full,
    output logic                    empty,
    input  wire logic               pop,
    output fpq8_pkg::t_out_item     o_result
);

    // The front decodes each beat, works out every simple operation and the
    // compare flags, and holds up to two decoded beats in a small queue.
    logic            front_valid;
    fpq8_pkg::t_work front_work;
    logic            back_take;

    fpq8_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .i_item  (i_item),
        .full    (full),
        .i_take  (back_take),
        .o_valid (front_valid),
        .o_work  (front_work)
    );

    // The back is a lockstep pipeline: the multiplier and its rounding sit in the
    // first stages and the restoring divider runs through all of them, so results
    // leave in order. The whole pipeline holds only while its output register is
    // full and not being popped; the front queue then absorbs incoming beats.
    fpq8_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (front_valid),
        .i_work   (front_work),
        .o_take   (back_take),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

@@ design/fpq8_front.sv @@
`default_nettype none
module fpq8_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             push,
    input  wire fpq8_pkg::t_in_item i_item,
    output logic                  full,
    input  wire logic             i_take,
    output logic                  o_valid,
    output fpq8_pkg::t_work       o_work
);

    fpq8_pkg::t_work n_work;
    fpq8_pkg::t_work r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            do_push;
    logic            do_pop;
    logic signed [31:0] a;
    logic signed [31:0] b;

    always_comb begin
        a = i_item.operand_a;
        b = i_item.operand_b;
        n_work.kind = fpq8_pkg::K_SIMPLE;
        n_work.neg = a[31] ^ b[31];
        n_work.mag_a = a[31] ? 32'd0 - a : a;
        n_work.mag_b = b[31] ? 32'd0 - b : b;
        n_work.out.less = a < b;
        n_work.out.equal = a == b;
        n_work.out.greater = a > b;
        n_work.out.range_error = 1'b0;
        n_work.out.divide_by_zero = 1'b0;
        n_work.out.result = '0;
        case (i_item.opcode)
            fpq8_pkg::OP_ADD:        n_work.out.result = a + b;
            fpq8_pkg::OP_SUB:        n_work.out.result = a - b;
            fpq8_pkg::OP_MUL:        n_work.kind = fpq8_pkg::K_MUL;
            fpq8_pkg::OP_DIV: begin
                if (b == 32'sd0) begin
                    n_work.out.divide_by_zero = 1'b1;
                    n_work.out.range_error = 1'b1;
                    n_work.out.result = a[31] ? fpq8_pkg::SAT_MIN : fpq8_pkg::SAT_MAX;
                end else begin
                    n_work.kind = fpq8_pkg::K_DIV;
                end
            end
            fpq8_pkg::OP_CMP:        n_work.out.result = a;
            fpq8_pkg::OP_MIN:        n_work.out.result = (a <= b) ? a : b;
            fpq8_pkg::OP_MAX:        n_work.out.result = (a >= b) ? a : b;
            fpq8_pkg::OP_INC:        n_work.out.result = a + 32'sd1;
            fpq8_pkg::OP_DEC:        n_work.out.result = a - 32'sd1;
            fpq8_pkg::OP_INT_TO_FIX: n_work.out.result = a <<< fpq8_pkg::FRAC_BITS;
            fpq8_pkg::OP_FIX_TO_INT: n_work.out.result = a >>> fpq8_pkg::FRAC_BITS;
            default:                 n_work.out.result = '0;
        endcase
    end

    assign full    = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_work  = r_mem[r_rp];
    assign do_push = push && !full;
    assign do_pop  = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= n_work;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule
`default_nettype wire

@@ design/fpq8_back.sv @@
`default_nettype none
module fpq8_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire fpq8_pkg::t_work i_work,
    output logic                 o_take,
    output logic                 empty,
    input  wire logic            pop,
    output fpq8_pkg::t_out_item  o_result
);

    localparam int NW = fpq8_pkg::NUM_W;

    logic            r_v   [NW+1];
    fpq8_pkg::t_work r_w   [NW+1];
    logic [31:0]     r_rem [NW+1];
    logic [NW-1:0]   r_qn  [NW+1];
    logic [31:0]     n_rem [NW];
    logic [NW-1:0]   n_qn  [NW];
    logic [63:0]     r_prod;
    fpq8_pkg::t_work n_w2;
    logic            r_ov;
    fpq8_pkg::t_out_item r_out;
    fpq8_pkg::t_out_item n_out;
    logic            en;
    logic [32:0]     trial [NW];
    logic [63:0]     mul_q;
    logic [32:0]     mul_sat;
    logic [NW:0]     div_q;
    logic [32:0]     div_sat;

    assign en       = !r_ov || pop;
    assign o_take   = en;
    assign empty    = !r_ov;
    assign o_result = r_out;

    // One restoring step per stage: a quotient bit enters at the bottom of r_qn.
    always_comb begin
        for (int s = 0; s < NW; s++) begin
            trial[s] = {r_rem[s], r_qn[s][NW-1]};
            if (trial[s] >= {1'b0, r_w[s].mag_b}) begin
                n_rem[s] = 32'(trial[s] - {1'b0, r_w[s].mag_b});
                n_qn[s]  = {r_qn[s][NW-2:0], 1'b1};
            end else begin
                n_rem[s] = trial[s][31:0];
                n_qn[s]  = {r_qn[s][NW-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        mul_q   = (r_prod + (64'd1 << (fpq8_pkg::FRAC_BITS - 1))) >> fpq8_pkg::FRAC_BITS;
        mul_sat = fpq8_pkg::signed_sat(r_w[1].neg, mul_q);
        n_w2    = r_w[1];
        if (r_w[1].kind == fpq8_pkg::K_MUL) begin
            n_w2.out.result      = mul_sat[31:0];
            n_w2.out.range_error = mul_sat[32];
        end
    end

    always_comb begin
        div_q = {1'b0, r_qn[NW]} +
                {{NW{1'b0}}, ({r_rem[NW], 1'b0} >= {1'b0, r_w[NW].mag_b})};
        div_sat = fpq8_pkg::signed_sat(r_w[NW].neg, 64'(div_q));
        n_out = r_w[NW].out;
        if (r_w[NW].kind == fpq8_pkg::K_DIV) begin
            n_out.result      = div_sat[31:0];
            n_out.range_error = div_sat[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w[0]   <= i_work;
            r_rem[0] <= '0;
            r_qn[0]  <= {i_work.mag_a, {fpq8_pkg::FRAC_BITS{1'b0}}};
            r_prod   <= {32'd0, r_w[0].mag_a} * {32'd0, r_w[0].mag_b};
            for (int s = 0; s < NW; s++) begin
                r_rem[s+1] <= n_rem[s];
                r_qn[s+1]  <= n_qn[s];
                if (s == 1) begin
                    r_w[s+1] <= n_w2;
                end else begin
                    r_w[s+1] <= r_w[s];
                end
            end
            r_out <= n_out;
        end
        if (!i_rst_n) begin
            for (int s = 0; s <= NW; s++) begin
                r_v[s] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int s = 0; s < NW; s++) begin
                r_v[s+1] <= r_v[s];
            end
            r_ov <= r_v[NW];
        end
    end

endmodule
`default_nettype wire
